// ----- sv/kac_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the key decode table for the keypad alarm controller.
// No dependencies; every other file of the block imports this package.
package kac_pkg;

  // Length of the user code in digits.
  localparam int CodeDigits = 5;
  // The cursor counts from zero up to and including CodeDigits.
  localparam int CurW = $clog2(CodeDigits + 1);
  // Index into a code store.
  localparam int IdxW = (CodeDigits > 1) ? $clog2(CodeDigits) : 1;
  // Tick counter of the timed phases, saturating at its all-ones value.
  localparam int CntW = 9;

  localparam int DigitW = 4;
  localparam int SecW = 8;
  localparam int ModeW = 3;
  localparam int ShownW = 3;

  // Request types.
  localparam logic [1:0] REQ_KEY  = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_TRIG = 2'd2;

  // Decoded key codes: digits 0 to 9, then the control keys.
  localparam logic [3:0] KEY_DEL = 4'd10;
  localparam logic [3:0] KEY_OK  = 4'd11;
  localparam logic [3:0] KEY_A   = 4'd12;
  localparam logic [3:0] KEY_B   = 4'd13;
  localparam logic [3:0] KEY_C   = 4'd14;
  localparam logic [3:0] KEY_D   = 4'd15;

  // Configuration register indexes.
  localparam logic CFG_ENTRY_DELAY    = 1'b0;
  localparam logic CFG_ALARM_DURATION = 1'b1;

  // Write and copy commands from the controller to the code stores.
  typedef struct packed {
    logic              wr;
    logic [IdxW-1:0]   idx;
    logic [DigitW-1:0] digit;
    logic              copy;
  } store_cmd_t;

  // One result as it leaves the controller.
  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic              alarm_out;
    logic              led;
    logic              send_alert;
    logic [SecW-1:0]   seconds_left;
    logic [ShownW-1:0] digits_entered;
    logic              wrong_password;
  } result_t;

  // Raw row-major keypad position to key code.
  function automatic logic [3:0] key_decode(input logic [3:0] pos);
    logic [3:0] code;
    unique case (pos)
      4'd0:  code = 4'd1;
      4'd1:  code = 4'd2;
      4'd2:  code = 4'd3;
      4'd3:  code = KEY_A;
      4'd4:  code = 4'd4;
      4'd5:  code = 4'd5;
      4'd6:  code = 4'd6;
      4'd7:  code = KEY_B;
      4'd8:  code = 4'd7;
      4'd9:  code = 4'd8;
      4'd10: code = 4'd9;
      4'd11: code = KEY_C;
      4'd12: code = KEY_OK;
      4'd13: code = 4'd0;
      4'd14: code = KEY_DEL;
      4'd15: code = KEY_D;
    endcase
    return code;
  endfunction

endpackage

// ----- sv/kac_code_store.sv -----
`timescale 1ns / 1ps
// Entry buffer and stored code of the keypad alarm controller, with the code compare.
// Depends on kac_pkg.
module kac_code_store (
  input  logic              clk,
  input  kac_pkg::store_cmd_t cmd,
  output logic              match
);
  import kac_pkg::*;

  logic [DigitW-1:0] entry_r  [CodeDigits];
  logic [DigitW-1:0] stored_r [CodeDigits];

  // Neither store is reset; both are written before they are ever compared.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      entry_r[cmd.idx] <= cmd.digit;
    end
    if (cmd.copy) begin
      for (int i = 0; i < CodeDigits; i++) begin
        stored_r[i] <= entry_r[i];
      end
    end
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CodeDigits; i++) begin
      if (entry_r[i] != stored_r[i]) begin
        match = 1'b0;
      end
    end
  end

endmodule

// ----- sv/kac_ctrl.sv -----
`timescale 1ns / 1ps
// Mode sequencer of the keypad alarm controller: mode, cursor, tick counter and LED.
// Depends on kac_pkg and kac_code_store.
module kac_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [1:0]           req_type,
  input  logic [3:0]           key_code,
  input  logic [7:0]           entry_delay,
  input  logic [7:0]           alarm_duration,
  output kac_pkg::result_t     result
);
  import kac_pkg::*;

  typedef enum logic [2:0] {
    MODE_WELCOME  = 3'd0,
    MODE_SET      = 3'd1,
    MODE_CONFIRM  = 3'd2,
    MODE_OFF      = 3'd3,
    MODE_ARMING   = 3'd4,
    MODE_ARMED    = 3'd5,
    MODE_DISARM   = 3'd6,
    MODE_ALARM    = 3'd7
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [CurW-1:0]  cursor_r, cursor_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             led_r, led_nxt;

  store_cmd_t       cmd;
  logic             match;

  logic             is_key, is_tick, is_trig, is_digit;
  logic             ok_full;
  logic [CntW-1:0]  count_inc;
  logic             alert, wrong;
  logic [SecW-1:0]  limit;

  kac_code_store u_store (
    .clk   (clk),
    .cmd   (cmd),
    .match (match)
  );

  assign is_key   = (req_type == REQ_KEY);
  assign is_tick  = (req_type == REQ_TICK);
  assign is_trig  = (req_type == REQ_TRIG);
  assign is_digit = (key_code < KEY_DEL);
  assign ok_full  = (key_code == KEY_OK) && (cursor_r >= CurW'(CodeDigits));
  assign count_inc = (count_r == {CntW{1'b1}}) ? count_r : count_r + CntW'(1);

  always_comb begin
    mode_nxt   = mode_r;
    cursor_nxt = cursor_r;
    count_nxt  = count_r;
    led_nxt    = led_r;
    alert      = 1'b0;
    wrong      = 1'b0;
    cmd.wr     = 1'b0;
    cmd.idx    = cursor_r[IdxW-1:0];
    cmd.digit  = key_code;
    cmd.copy   = 1'b0;

    // Digit and delete editing, shared by code setting and disarm entry.
    if ((mode_r == MODE_SET || mode_r == MODE_DISARM) && is_key) begin
      if (is_digit && cursor_r < CurW'(CodeDigits)) begin
        cmd.wr     = 1'b1;
        cursor_nxt = cursor_r + CurW'(1);
      end else if (key_code == KEY_DEL && cursor_r != '0) begin
        cursor_nxt = cursor_r - CurW'(1);
      end
    end

    unique case (mode_r)
      MODE_WELCOME: begin
        if (is_key) begin
          mode_nxt   = MODE_SET;
          cursor_nxt = '0;
        end
      end
      MODE_SET: begin
        if (is_key && ok_full) begin
          cmd.copy = 1'b1;
          mode_nxt = MODE_CONFIRM;
        end
      end
      MODE_CONFIRM: begin
        if (is_key && key_code == KEY_OK) begin
          mode_nxt = MODE_OFF;
        end
      end
      MODE_OFF: begin
        if (is_key && key_code == KEY_A) begin
          mode_nxt  = MODE_ARMING;
          count_nxt = '0;
        end else if (is_key && key_code == KEY_B) begin
          mode_nxt   = MODE_SET;
          cursor_nxt = '0;
        end
      end
      MODE_ARMING: begin
        if (is_key && key_code == KEY_OK) begin
          mode_nxt = MODE_ARMED;
        end else if (is_tick) begin
          count_nxt = count_inc;
          if (count_inc > CntW'(entry_delay)) begin
            mode_nxt = MODE_ARMED;
          end
        end
      end
      MODE_ARMED: begin
        if (is_key || is_trig) begin
          mode_nxt   = MODE_DISARM;
          count_nxt  = '0;
          cursor_nxt = '0;
        end
      end
      MODE_DISARM: begin
        if (is_key && ok_full) begin
          if (match) begin
            mode_nxt = MODE_OFF;
          end else begin
            wrong      = 1'b1;
            cursor_nxt = '0;
          end
        end else if (is_tick) begin
          count_nxt = count_inc;
          if (count_inc > CntW'(entry_delay)) begin
            mode_nxt  = MODE_ALARM;
            count_nxt = '0;
          end
        end
      end
      MODE_ALARM: begin
        if (is_tick) begin
          led_nxt   = ~led_r;
          alert     = 1'b1;
          count_nxt = count_inc;
          if (count_inc > CntW'(alarm_duration)) begin
            mode_nxt = MODE_ARMED;
            led_nxt  = 1'b0;
          end
        end
      end
    endcase

    if (!step) begin
      cmd.wr   = 1'b0;
      cmd.copy = 1'b0;
    end
  end

  // The result describes the state after the request.
  always_comb begin
    limit = (mode_nxt == MODE_ALARM) ? alarm_duration : entry_delay;
    result.mode           = mode_nxt;
    result.alarm_out      = (mode_nxt == MODE_ALARM);
    result.led            = led_nxt;
    result.send_alert     = alert;
    result.seconds_left   = '0;
    result.digits_entered = '0;
    result.wrong_password = wrong;
    if (mode_nxt == MODE_ARMING || mode_nxt == MODE_DISARM || mode_nxt == MODE_ALARM) begin
      if (count_nxt < CntW'(limit)) begin
        result.seconds_left = limit - count_nxt[SecW-1:0];
      end
    end
    if (mode_nxt == MODE_SET || mode_nxt == MODE_DISARM) begin
      result.digits_entered = ShownW'(cursor_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_WELCOME;
      cursor_r <= '0;
      count_r  <= '0;
      led_r    <= 1'b0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      cursor_r <= cursor_nxt;
      count_r  <= count_nxt;
      led_r    <= led_nxt;
    end
  end

endmodule

// ----- sv/keypad_alarm_controller_unit.sv -----
`timescale 1ns / 1ps
// Keypad alarm controller: request and result registers around the mode sequencer.
// Depends on kac_pkg, kac_ctrl and kac_code_store.
//
// Usage. Each request on the input channel (in_valid, in_stall) is a key press,
// a one-second tick or an intrusion trigger, and yields exactly one result on the
// output channel (out_valid, out_stall) describing the panel after that request.
// A request is taken when in_valid is high and in_stall is low, and a result is
// taken when out_valid is high and out_stall is low.
// The request is captured in the input register; the sequencer then updates its
// state and loads the result register once that register is free or being emptied.
// While the receiver does not stall, a new request is accepted every cycle, one
// request per clock, with a single sequencer step between the two registers.
// When the receiver stalls, the pending result holds and the captured request
// waits in the input register; in_stall rises only once both are occupied.
// The configuration port sets the entry delay (index 0) and the alarm duration
// (index 1) in ticks; write it only while no request is in flight.
// Synchronous reset returns the panel to welcome mode, clears the cursor, tick
// counter and LED, empties both registers and loads the delays 20 and 60. The
// code stores are not reset; they are always written before being compared.
module keypad_alarm_controller_unit (
  input  logic       clk,
  input  logic       rst_n,
  // Request channel.
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [3:0] in_key_index,
  // Result channel.
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_mode,
  output logic       out_alarm_out,
  output logic       out_led,
  output logic       out_send_alert,
  output logic [7:0] out_seconds_left,
  output logic [2:0] out_digits_entered,
  output logic       out_wrong_password,
  // Configuration port.
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import kac_pkg::*;

  logic       in_full_r, in_full_nxt;
  logic [1:0] req_r;
  logic [3:0] key_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    res_r;
  result_t    res;
  logic [7:0] entry_delay_r, alarm_duration_r;
  logic       advance, in_take;

  // The sequencer steps whenever a request is held and the result register is
  // free or being emptied in this cycle.
  assign advance  = in_full_r && (!out_valid_r || !out_stall);
  assign in_stall = in_full_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign in_full_nxt   = in_take || (in_full_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  kac_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .req_type       (req_r),
    .key_code       (key_decode(key_r)),
    .entry_delay    (entry_delay_r),
    .alarm_duration (alarm_duration_r),
    .result         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r        <= 1'b0;
      out_valid_r      <= 1'b0;
      entry_delay_r    <= 8'd20;
      alarm_duration_r <= 8'd60;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_ENTRY_DELAY:    entry_delay_r    <= cfg_data;
          CFG_ALARM_DURATION: alarm_duration_r <= cfg_data;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= in_req_type;
      key_r <= in_key_index;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mode           = res_r.mode;
  assign out_alarm_out      = res_r.alarm_out;
  assign out_led            = res_r.led;
  assign out_send_alert     = res_r.send_alert;
  assign out_seconds_left   = res_r.seconds_left;
  assign out_digits_entered = res_r.digits_entered;
  assign out_wrong_password = res_r.wrong_password;

endmodule

// ----- verif/kac_result_checker.sv -----
`timescale 1ns / 1ps
// Panel-mode names shared with the testbench top, and the result checker that predicts
// every result of the keypad alarm controller and compares it. Depends on kac_pkg.
package kac_tb_pkg;

  typedef enum logic [2:0] {
    M_WELCOME,
    M_SET_ENTRY,
    M_SET_CONFIRM,
    M_OFF,
    M_ARMING,
    M_ARMED,
    M_DISARM,
    M_ALARM
  } panel_mode_t;

endpackage

module kac_result_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic [1:0]                            in_req_type,
  input  logic [3:0]                            in_key_index,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic [2:0]                            out_mode,
  input  logic                                  out_alarm_out,
  input  logic                                  out_led,
  input  logic                                  out_send_alert,
  input  logic [7:0]                            out_seconds_left,
  input  logic [2:0]                            out_digits_entered,
  input  logic                                  out_wrong_password,
  input  logic                                  cfg_wr_en,
  input  logic                                  cfg_index,
  input  logic [7:0]                            cfg_data,
  output int                                    fail_count,
  output int                                    pending,
  output kac_tb_pkg::panel_mode_t               model_mode,
  output logic [2:0]                            model_cursor,
  output logic [kac_pkg::CodeDigits-1:0][3:0]   model_code
);
  import kac_pkg::*;
  import kac_tb_pkg::*;

  // Predicted panel state, updated as each request is accepted.
  panel_mode_t                 mode_q;
  logic [CodeDigits-1:0][3:0]  code_q;
  logic [CodeDigits-1:0][3:0]  entry_q;
  logic [2:0]                  cur_q;
  logic [CntW-1:0]             secs_q;
  logic                        led_q;
  logic [7:0]                  entry_delay_q;
  logic [7:0]                  alarm_len_q;

  // Results still owed by the block, oldest first.
  result_t panel_reports_q[$];

  assign model_mode   = mode_q;
  assign model_cursor = cur_q;
  assign model_code   = code_q;

  // The keypad is four rows of four: the last column holds A to D, the bottom row
  // holds OK, zero and delete, and the rest count the digits 1 to 9.
  function automatic logic [3:0] key_of_pos(input logic [3:0] pos);
    logic [1:0] row;
    logic [1:0] col;
    row = pos[3:2];
    col = pos[1:0];
    if (col == 2'd3) return KEY_A + row;
    else if (row != 2'd3) return 4'(row * 3 + col + 1);
    else if (col == 2'd0) return KEY_OK;
    else if (col == 2'd1) return 4'd0;
    else return KEY_DEL;
  endfunction

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Digit and delete editing; done is raised for OK on a full entry.
  task automatic edit_code(input logic [3:0] key, output logic done);
    done = 1'b0;
    if (key < KEY_DEL) begin
      if (cur_q < CodeDigits) begin
        entry_q[cur_q] = key;
        cur_q = cur_q + 1'b1;
      end
    end else if (key == KEY_DEL) begin
      if (cur_q != 0) cur_q = cur_q - 1'b1;
    end else if (key == KEY_OK) begin
      done = (cur_q >= CodeDigits);
    end
  endtask

  task automatic advance_panel(input logic [1:0] req, input logic [3:0] pos,
                               output result_t res);
    logic [3:0] key;
    logic       done;
    logic       is_key;
    logic       is_tick;
    logic       is_trig;
    logic [7:0] limit;
    key     = key_of_pos(pos);
    is_key  = (req == REQ_KEY);
    is_tick = (req == REQ_TICK);
    is_trig = (req == REQ_TRIG);
    res     = '0;
    case (mode_q)
      M_WELCOME: begin
        if (is_key) begin
          mode_q = M_SET_ENTRY;
          cur_q  = '0;
        end
      end
      M_SET_ENTRY: begin
        if (is_key) begin
          edit_code(key, done);
          if (done) begin
            code_q = entry_q;
            mode_q = M_SET_CONFIRM;
          end
        end
      end
      M_SET_CONFIRM: begin
        if (is_key && key == KEY_OK) mode_q = M_OFF;
      end
      M_OFF: begin
        if (is_key && key == KEY_A) begin
          mode_q = M_ARMING;
          secs_q = '0;
        end else if (is_key && key == KEY_B) begin
          mode_q = M_SET_ENTRY;
          cur_q  = '0;
        end
      end
      M_ARMING: begin
        if (is_key && key == KEY_OK) begin
          mode_q = M_ARMED;
        end else if (is_tick) begin
          secs_q = sat_inc(secs_q);
          if (secs_q > entry_delay_q) mode_q = M_ARMED;
        end
      end
      M_ARMED: begin
        if (is_key || is_trig) begin
          mode_q = M_DISARM;
          secs_q = '0;
          cur_q  = '0;
        end
      end
      M_DISARM: begin
        if (is_key) begin
          edit_code(key, done);
          if (done) begin
            if (entry_q == code_q) begin
              mode_q = M_OFF;
            end else begin
              res.wrong_password = 1'b1;
              cur_q = '0;
            end
          end
        end else if (is_tick) begin
          secs_q = sat_inc(secs_q);
          if (secs_q > entry_delay_q) begin
            mode_q = M_ALARM;
            secs_q = '0;
          end
        end
      end
      default: begin
        if (is_tick) begin
          led_q = ~led_q;
          res.send_alert = 1'b1;
          secs_q = sat_inc(secs_q);
          if (secs_q > alarm_len_q) begin
            mode_q = M_ARMED;
            led_q  = 1'b0;
          end
        end
      end
    endcase

    limit = (mode_q == M_ALARM) ? alarm_len_q : entry_delay_q;
    if (mode_q == M_ARMING || mode_q == M_DISARM || mode_q == M_ALARM)
      res.seconds_left = (secs_q >= limit) ? 8'd0 : 8'(limit - secs_q);
    if (mode_q == M_SET_ENTRY || mode_q == M_DISARM)
      res.digits_entered = cur_q;
    res.mode      = mode_q;
    res.alarm_out = (mode_q == M_ALARM);
    res.led       = led_q;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t res;
    if (!rst_n) begin
      mode_q        = M_WELCOME;
      cur_q         = '0;
      secs_q        = '0;
      led_q         = 1'b0;
      code_q        = '0;
      entry_q       = '0;
      entry_delay_q = 8'd20;
      alarm_len_q   = 8'd60;
      fail_count    = 0;
      panel_reports_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ENTRY_DELAY:    entry_delay_q = cfg_data;
          CFG_ALARM_DURATION: alarm_len_q   = cfg_data;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_panel(in_req_type, in_key_index, res);
        panel_reports_q.push_back(res);
      end
      if (out_valid && !out_stall) begin
        if (panel_reports_q.size() == 0) begin
          $error("result with no request outstanding: mode %0d", out_mode);
          fail_count++;
        end else begin
          res = panel_reports_q.pop_front();
          check_field("mode", res.mode, out_mode);
          check_field("alarm_out", res.alarm_out, out_alarm_out);
          check_field("led", res.led, out_led);
          check_field("send_alert", res.send_alert, out_send_alert);
          check_field("seconds_left", res.seconds_left, out_seconds_left);
          check_field("digits_entered", res.digits_entered, out_digits_entered);
          check_field("wrong_password", res.wrong_password, out_wrong_password);
        end
      end
    end
    pending = panel_reports_q.size();
  end

endmodule

// ----- verif/tb_keypad_alarm_controller_unit.sv -----
`timescale 1ns / 1ps
// Testbench top for the keypad alarm controller: clock, reset, request stimulus,
// result stalling, timing settings and the verdict. Depends on kac_pkg and kac_result_checker.
module tb_keypad_alarm_controller_unit;
  import kac_pkg::*;
  import kac_tb_pkg::*;

  localparam int RESET_CYCLES    = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int N_PHASES        = 7;
  localparam int HOLD_CYCLES     = 48;
  localparam int DRAIN_CYCLES    = 6;
  localparam int QUIET_LIMIT     = 1000;
  localparam int NOISE_PCT       = 10;

  // Request type that the block treats as no event at all.
  localparam logic [1:0] REQ_NONE = 2'd3;

  // Raw keypad positions of the control keys.
  localparam logic [3:0] POS_A   = 4'd3;
  localparam logic [3:0] POS_B   = 4'd7;
  localparam logic [3:0] POS_C   = 4'd11;
  localparam logic [3:0] POS_OK  = 4'd12;
  localparam logic [3:0] POS_DEL = 4'd14;
  localparam logic [3:0] POS_D   = 4'd15;

  // How a disarm window is meant to end: the right code, a wrong code, or a timeout.
  typedef enum logic [1:0] {PLAN_CODE, PLAN_WRONG, PLAN_WAIT} disarm_plan_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_req_type;
  logic [3:0] in_key_index;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_mode;
  logic       out_alarm_out;
  logic       out_led;
  logic       out_send_alert;
  logic [7:0] out_seconds_left;
  logic [2:0] out_digits_entered;
  logic       out_wrong_password;
  logic       cfg_wr_en;
  logic       cfg_index;
  logic [7:0] cfg_data;

  int                         fail_count;
  int                         pending;
  panel_mode_t                model_mode;
  logic [2:0]                 model_cursor;
  logic [CodeDigits-1:0][3:0] model_code;

  // Idling rates in percent, set per phase by the stimulus process. The directed walk
  // runs at the rates of the first phase.
  int unsigned  send_gap_pct = 6;
  int unsigned  recv_stall_pct = 61;
  bit           hold_request = 1'b0;
  int           n_sent = 0;
  int           n_settings = 0;
  int           quiet_cycles = 0;
  logic [7:0]   modes_seen = '0;
  panel_mode_t  prev_mode = M_WELCOME;
  disarm_plan_t plan = PLAN_CODE;
  bit           replan = 1'b0;

  always #5 clk = ~clk;

  keypad_alarm_controller_unit i_dut (.*);

  kac_result_checker i_checker (.*);

  // Digits 1 to 9 fill the first three columns row by row; zero sits in the bottom row.
  function automatic logic [3:0] pos_of_digit(input logic [3:0] d);
    if (d == 4'd0) return 4'd13;
    return 4'(d - 1 + (d - 1) / 3);
  endfunction

  // Offers one request from a falling edge, with random gaps before it, and returns at
  // the falling edge after it has been taken. in_valid is left high so that a following
  // request can be offered back to back.
  task automatic offer_request(input logic [1:0] req, input logic [3:0] pos);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    modes_seen[model_mode] = 1'b1;
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_key_index <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  // Stops offering and waits until every result has come back, then idles for a drain period.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes both timing registers on consecutive cycles.
  task automatic set_timing(input logic [7:0] entry_delay, input logic [7:0] alarm_len);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ENTRY_DELAY;
    cfg_data  <= entry_delay;
    @(negedge clk);
    cfg_index <= CFG_ALARM_DURATION;
    cfg_data  <= alarm_len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  // Chooses the next request from the predicted panel state. Most requests move the
  // panel along its intended path so that the deep modes are reached often; a share of
  // fully random requests, including the unused request type, is mixed in everywhere.
  task automatic pick_request(output logic [1:0] req, output logic [3:0] pos);
    int unsigned roll;
    int unsigned pick;
    logic [3:0]  digit;
    roll  = $urandom_range(0, 99);
    pick  = $urandom_range(0, 99);
    digit = 4'($urandom_range(0, 9));
    req   = REQ_KEY;
    pos   = 4'($urandom_range(0, 15));

    // A fresh disarm window, or a wrong code just entered, decides how it will end.
    if (model_mode == M_DISARM && (prev_mode != M_DISARM || replan)) begin
      pick = $urandom_range(0, 99);
      plan = (pick < 45) ? PLAN_CODE : (pick < 75) ? PLAN_WRONG : PLAN_WAIT;
      pick = $urandom_range(0, 99);
    end
    replan    = 1'b0;
    prev_mode = model_mode;

    if (roll < NOISE_PCT) begin
      req = 2'($urandom_range(0, 3));
    end else begin
      case (model_mode)
        M_WELCOME: ;  // any key wakes the panel
        M_SET_ENTRY: begin
          if (model_cursor < CodeDigits)
            pos = (pick < 80) ? pos_of_digit(digit) : (pick < 90) ? POS_DEL : POS_OK;
          else
            pos = (pick < 75) ? POS_OK : (pick < 90) ? POS_DEL : pos_of_digit(digit);
        end
        M_SET_CONFIRM: begin
          if (pick < 80) pos = POS_OK;
        end
        M_OFF: begin
          if (pick < 80) pos = POS_A;
          else if (pick < 90) pos = POS_B;
        end
        M_ARMING: begin
          if (pick < 85) req = REQ_TICK;
          else if (pick < 93) pos = POS_OK;
        end
        M_ARMED: begin
          if (pick < 50) req = REQ_TRIG;
        end
        M_DISARM: begin
          case (plan)
            PLAN_CODE: begin
              if (model_cursor < CodeDigits)
                if (pick < 90) pos = pos_of_digit(model_code[model_cursor]);
                else if (pick < 95) pos = POS_DEL;
                else req = REQ_TICK;
              else
                pos = (pick < 90) ? POS_OK : POS_DEL;
            end
            PLAN_WRONG: begin
              if (model_cursor < CodeDigits) begin
                if (pick < 90) pos = pos_of_digit(digit);
                else req = REQ_TICK;
              end else begin
                pos    = POS_OK;
                replan = 1'b1;
              end
            end
            default: begin
              if (pick < 90) req = REQ_TICK;
            end
          endcase
        end
        default: begin
          if (pick < 85) req = REQ_TICK;
          else req = 2'($urandom_range(0, 3));
        end
      endcase
    end
  endtask

  // Result side: random stalls at the current rate, or a long hold-off on request, which
  // lets the block fill up and push back on its input.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: the run is abandoned if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_keypad_alarm_controller_unit: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int         p;
    int         n;
    int         i;
    logic [1:0] req;
    logic [3:0] pos;

    in_valid     <= 1'b0;
    in_req_type  <= REQ_KEY;
    in_key_index <= '0;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= CFG_ENTRY_DELAY;
    cfg_data     <= '0;
    rst_n        <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk through the main path at the reset timing. Ticks, triggers and
    // the unused request type are ignored in welcome mode, and the waking key is
    // swallowed rather than typed.
    offer_request(REQ_TICK, POS_D);
    offer_request(REQ_TRIG, POS_A);
    offer_request(REQ_NONE, POS_D);
    offer_request(REQ_KEY, POS_D);
    // OK on an empty entry and delete on an empty entry are both ignored.
    offer_request(REQ_KEY, POS_OK);
    offer_request(REQ_KEY, POS_DEL);
    offer_request(REQ_KEY, pos_of_digit(4'd0));
    offer_request(REQ_KEY, pos_of_digit(4'd1));
    offer_request(REQ_KEY, pos_of_digit(4'd9));
    offer_request(REQ_KEY, pos_of_digit(4'd5));
    offer_request(REQ_KEY, POS_DEL);
    offer_request(REQ_KEY, pos_of_digit(4'd8));
    offer_request(REQ_KEY, pos_of_digit(4'd6));
    // A digit on a full entry is dropped; OK stores the code and a second OK confirms it,
    // with an unrelated key in between that the confirm step ignores.
    offer_request(REQ_KEY, pos_of_digit(4'd3));
    offer_request(REQ_KEY, POS_OK);
    offer_request(REQ_KEY, POS_A);
    offer_request(REQ_KEY, POS_OK);
    // Off: a tick does nothing, A starts arming and OK cuts it short.
    offer_request(REQ_TICK, POS_C);
    offer_request(REQ_KEY, POS_A);
    offer_request(REQ_KEY, POS_OK);
    // An intrusion opens the disarm window and the stored code closes it.
    offer_request(REQ_TRIG, POS_B);
    for (i = 0; i < CodeDigits; i++) offer_request(REQ_KEY, pos_of_digit(model_code[i]));
    offer_request(REQ_KEY, POS_OK);

    // Random phases, each under its own timing setting. The block is drained before
    // every setting so that no request is in flight when the registers change. The
    // sender idles lightly while the receiver stalls hard, then the reverse, then
    // neither; two phases also open with a long result hold-off.
    for (p = 0; p < N_PHASES; p++) begin
      settle();
      case (p)
        0: set_timing(8'd8, 8'd12);
        1: set_timing(8'd0, 8'd0);
        2: set_timing(8'd255, 8'd3);
        3: set_timing(8'd2, 8'd255);
        4: set_timing(8'd1, 8'd1);
        5: set_timing(8'd255, 8'd255);
        default: set_timing(8'd5, 8'd9);
      endcase
      if (p < 2) begin
        send_gap_pct   = 6;
        recv_stall_pct = 61;
      end else if (p < 4) begin
        send_gap_pct   = 61;
        recv_stall_pct = 6;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      if (p == 1 || p == 4) hold_request = 1'b1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick_request(req, pos);
        offer_request(req, pos);
      end
    end
    settle();

    $display("Covered %0d requests under %0d timing settings, extremes 0 and 255 included;",
             n_sent, n_settings);
    $display("%0d of 8 panel modes reached, with idling on both sides and long hold-offs.",
             $countones(modes_seen));
    if (fail_count == 0 && pending == 0) begin
      $display("tb_keypad_alarm_controller_unit: clean");
    end else begin
      $display("tb_keypad_alarm_controller_unit: errors");
    end
    $finish;
  end

endmodule
